FILE: rtl/core/mstw_pkg.sv
// Shared types and constants for the multi-slot task watchdog.
// Used by the front end, the command queue, the slot engine and the top level.
// No dependencies.
package mstw_pkg;

    // Number of watchdog slots in the table (1 to 32).
    localparam int SLOTS        = 8;
    localparam int SLOT_IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // A handle is three bits wide, so registration can only claim slots 0..7.
    localparam int HANDLE_SLOTS = (SLOTS < 8) ? SLOTS : 8;
    localparam int MASK_W       = 8;
    localparam int FIRED_W      = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int IN_TDATA_W   = 112;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 16;

    // Item kinds as they arrive in tuser.
    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_KICK     = 2'd1;
    localparam logic [1:0] MODE_CHECK    = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_REGISTER,
        OP_KICK,
        OP_CHECK
    } op_t;

    // A classified command as it travels from the front end to the engine.
    typedef struct packed {
        op_t                op;
        logic               kick_ok;
        logic [SLOT_IW-1:0] slot;
        logic [63:0]        now_ms;
        logic [31:0]        interval_ms;
        logic [7:0]         miss_limit;
        logic               has_recovery;
    } cmd_t;

    // Result item; the last member sits in the lowest bits.
    typedef struct packed {
        logic [MASK_W-1:0]  recovery_mask;
        logic [FIRED_W-1:0] fired_count;
        logic               handle_valid;
        logic [2:0]         handle;
    } result_t;

endpackage

FILE: rtl/core/mstw_front.sv
// Front end of the watchdog: accepts input transactions and classifies them.
// Depends on mstw_pkg; feeds mstw_queue.
module mstw_front (
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: slot[2:0], now_ms[63:0], interval_ms[31:0],
    // miss_limit[7:0], has_recovery, four zero bits.
    input  logic [mstw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0 up: mode[1:0].
    input  logic [mstw_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                               queue_full,
    output logic                               push,
    output mstw_pkg::cmd_t                     push_cmd
);

    logic [2:0] slot_field;

    assign slot_field    = s_axis_tdata[2:0];
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb
    begin
        push_cmd.slot         = mstw_pkg::SLOT_IW'(slot_field);
        push_cmd.kick_ok      = (32'(slot_field) < mstw_pkg::SLOTS);
        push_cmd.now_ms       = s_axis_tdata[66:3];
        push_cmd.interval_ms  = s_axis_tdata[98:67];
        push_cmd.miss_limit   = s_axis_tdata[106:99];
        push_cmd.has_recovery = s_axis_tdata[107];
        unique case (s_axis_tuser)
            mstw_pkg::MODE_REGISTER: push_cmd.op = mstw_pkg::OP_REGISTER;
            mstw_pkg::MODE_KICK:     push_cmd.op = mstw_pkg::OP_KICK;
            mstw_pkg::MODE_CHECK:    push_cmd.op = mstw_pkg::OP_CHECK;
            default:                 push_cmd.op = mstw_pkg::OP_NONE;
        endcase
    end

endmodule

FILE: rtl/core/mstw_queue.sv
// Short command queue between the watchdog front end and the slot engine.
// Depends on mstw_pkg.
module mstw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mstw_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mstw_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (mstw_pkg::QUEUE_DEPTH > 1) ? $clog2(mstw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mstw_pkg::QUEUE_DEPTH + 1);

    mstw_pkg::cmd_t   entries [mstw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(mstw_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(mstw_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: rtl/core/mstw_engine.sv
// Slot engine of the watchdog: holds the slot table, executes commands and
// registers the result. Depends on mstw_pkg; fed by mstw_queue.
module mstw_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  mstw_pkg::cmd_t                     head_cmd,
    output logic                               pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0 up: handle[2:0], handle_valid, fired_count[3:0],
    // recovery_mask[7:0].
    output logic [mstw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int IW = mstw_pkg::SLOT_IW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                               state_reg, state_next;
    logic [IW-1:0]                        scan_idx_reg, scan_idx_next;
    mstw_pkg::cmd_t                       cmd_reg, cmd_next;
    logic [mstw_pkg::FIRED_W-1:0]         fired_reg, fired_next;
    logic [mstw_pkg::MASK_W-1:0]          mask_reg, mask_next;
    logic                                 out_valid_reg, out_valid_next;
    mstw_pkg::result_t                    out_data_reg, out_data_next;
    logic [mstw_pkg::SLOTS-1:0]           used_reg, used_next;

    // Slot table payload; a slot's fields only matter while it is used.
    logic [31:0] timeout_mem  [mstw_pkg::SLOTS];
    logic [7:0]  limit_mem    [mstw_pkg::SLOTS];
    logic [7:0]  misses_mem   [mstw_pkg::SLOTS];
    logic [63:0] last_mem     [mstw_pkg::SLOTS];
    logic        recovery_mem [mstw_pkg::SLOTS];

    logic          we_cfg;
    logic          we_last;
    logic          we_miss;
    logic [IW-1:0] wr_idx;
    logic [63:0]   wr_last;
    logic [7:0]    wr_miss;

    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          can_out;
    logic [63:0]   elapsed;
    logic          overdue;
    logic [7:0]    miss_inc;
    logic          fire;
    logic          last_slot;
    mstw_pkg::result_t res;

    // Lowest free slot that a handle can name.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mstw_pkg::HANDLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign can_out   = !out_valid_reg || m_axis_tready;
    assign elapsed   = cmd_reg.now_ms - last_mem[scan_idx_reg];
    assign overdue   = elapsed > {32'd0, timeout_mem[scan_idx_reg]};
    assign miss_inc  = misses_mem[scan_idx_reg] + 8'd1;
    assign fire      = miss_inc >= limit_mem[scan_idx_reg];
    assign last_slot = (scan_idx_reg == IW'(mstw_pkg::SLOTS - 1));

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmd_next       = cmd_reg;
        fired_next     = fired_reg;
        mask_next      = mask_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        we_cfg         = 1'b0;
        we_last        = 1'b0;
        we_miss        = 1'b0;
        wr_idx         = scan_idx_reg;
        wr_last        = cmd_reg.now_ms;
        wr_miss        = 8'd0;
        res            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && can_out)
                begin
                    pop = 1'b1;
                    unique case (head_cmd.op)
                        mstw_pkg::OP_REGISTER:
                        begin
                            res.handle_valid = free_found;
                            res.handle       = 3'(free_idx);
                            if (free_found)
                            begin
                                used_next[free_idx] = 1'b1;
                                we_cfg  = 1'b1;
                                we_last = 1'b1;
                                we_miss = 1'b1;
                                wr_idx  = free_idx;
                                wr_last = head_cmd.now_ms;
                            end
                            out_valid_next = 1'b1;
                            out_data_next  = res;
                        end
                        mstw_pkg::OP_KICK:
                        begin
                            if (head_cmd.kick_ok && used_reg[head_cmd.slot])
                            begin
                                we_last = 1'b1;
                                we_miss = 1'b1;
                                wr_idx  = head_cmd.slot;
                                wr_last = head_cmd.now_ms;
                            end
                            out_valid_next = 1'b1;
                            out_data_next  = res;
                        end
                        mstw_pkg::OP_CHECK:
                        begin
                            cmd_next      = head_cmd;
                            scan_idx_next = '0;
                            fired_next    = '0;
                            mask_next     = '0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = res;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (used_reg[scan_idx_reg] && overdue)
                begin
                    we_miss = 1'b1;
                    if (fire)
                    begin
                        we_last = 1'b1;
                        if (fired_reg != '1)
                            fired_next = fired_reg + mstw_pkg::FIRED_W'(1);
                        if (recovery_mem[scan_idx_reg] &&
                            (32'(scan_idx_reg) < mstw_pkg::MASK_W))
                            mask_next = mask_reg |
                                        (mstw_pkg::MASK_W'(1) << scan_idx_reg);
                    end
                    else
                    begin
                        wr_miss = miss_inc;
                    end
                end
                if (last_slot)
                    state_next = ST_FLUSH;
                else
                    scan_idx_next = scan_idx_reg + IW'(1);
            end
            ST_FLUSH:
            begin
                if (can_out)
                begin
                    res.fired_count   = fired_reg;
                    res.recovery_mask = mask_reg;
                    out_valid_next    = 1'b1;
                    out_data_next     = res;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            fired_reg     <= '0;
            mask_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            fired_reg     <= fired_next;
            mask_reg      <= mask_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (we_cfg)
        begin
            timeout_mem[wr_idx]  <= head_cmd.interval_ms;
            limit_mem[wr_idx]    <= head_cmd.miss_limit;
            recovery_mem[wr_idx] <= head_cmd.has_recovery;
        end
        if (we_last)
            last_mem[wr_idx] <= wr_last;
        if (we_miss)
            misses_mem[wr_idx] <= wr_miss;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Only slots that fired can appear in the recovery mask.
    a_mask_within_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones(out_data_reg.recovery_mask) <=
                           int'(out_data_reg.fired_count)))
        else $error("recovery mask reports more slots than fired");

    // A registration result never carries check information.
    a_register_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.handle_valid) |->
        (out_data_reg.fired_count == '0 && out_data_reg.recovery_mask == '0))
        else $error("registration result carries fire information");

    // A scan finishes through the flush state, never straight to idle.
    a_scan_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_FLUSH))
        else $error("scan left without flushing its result");

    // No command is taken while the engine is busy with a scan.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("command popped while engine busy");

endmodule

FILE: rtl/core/multi_slot_task_watchdog_core.sv
// Multi-slot task watchdog: register, kick and check over a table of slots.
// Register, kick and unknown items pass the queue; the engine executes each one
// and registers its result. A check registers its result after its scan.
// Throughput: one register or kick per cycle while results are taken; a check
// holds the engine for its scan, visiting one slot per cycle with one subtractor.
// Reset (rst_n low, asynchronous) empties the slot table and queue at once.
module multi_slot_task_watchdog_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: slot[2:0], now_ms[63:0], interval_ms[31:0],
    // miss_limit[7:0], has_recovery, four zero bits.
    input  logic [mstw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0 up: mode[1:0].
    input  logic [mstw_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0 up: handle[2:0], handle_valid, fired_count[3:0],
    // recovery_mask[7:0].
    output logic [mstw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // The front end decodes each transaction into a command and pushes it into
    // a short queue. The engine pops commands, executes them against the slot
    // table and parks each result in an output register, so the input side
    // can accept until the queue fills while a result waits for the downstream side.

    logic           push;
    mstw_pkg::cmd_t push_cmd;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    mstw_pkg::cmd_t head_cmd;

    mstw_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    mstw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The engine visits one slot per cycle during a check; registration finds
    // the lowest free slot from the used bits with combinational logic.
    mstw_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: dv/multi_slot_task_watchdog_core_tb.sv
// Self-checking testbench for multi_slot_task_watchdog_core: directed and random
// register, kick and check transactions, each predicted and checked field by field.
// Depends on mstw_pkg and the core RTL only.
module multi_slot_task_watchdog_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth item kind has no meaning in the block; it must be ignored.
    localparam logic [1:0]  MODE_RESERVED  = 2'd3;

    localparam int          RANDOM_REQS    = 950;
    localparam int          IDLE_PCT       = 30;
    // The receiver holds off once for a long stretch so the command queue fills.
    localparam int          STALL_AT       = 300;
    localparam int          STALL_CYCLES   = 200;
    // Window, counted in transactions, in which neither side idles.
    localparam int          QUIET_LO       = 500;
    localparam int          QUIET_HI       = 650;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 3 * mstw_pkg::SLOTS + 10;
    // Start just below the wrap point so elapsed times wrap modulo 2^64 early on.
    localparam logic [63:0] T0             = 64'hFFFF_FFFF_FFFF_FFF0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  slot;
        logic [63:0] now_ms;
        logic [31:0] interval_ms;
        logic [7:0]  miss_limit;
        logic        has_recovery;
    } wd_req_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [mstw_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [mstw_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [mstw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Own copy of the slot table, advanced once per accepted transaction.
    logic        wd_used      [mstw_pkg::SLOTS];
    logic [31:0] wd_timeout   [mstw_pkg::SLOTS];
    logic [7:0]  wd_limit     [mstw_pkg::SLOTS];
    logic [7:0]  wd_misses    [mstw_pkg::SLOTS];
    logic [63:0] wd_last_kick [mstw_pkg::SLOTS];
    logic        wd_recovery  [mstw_pkg::SLOTS];

    wd_req_t           pending_reqs[$];
    mstw_pkg::result_t expected_results[$];
    wd_req_t           offered_req;

    int error_count   = 0;
    int reqs_accepted = 0;
    int results_seen  = 0;
    int stall_left    = 0;
    bit stall_done    = 1'b0;

    multi_slot_task_watchdog_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wd_req_t make_req(logic [1:0] mode, logic [2:0] slot,
                                         logic [63:0] now_ms, logic [31:0] interval_ms,
                                         logic [7:0] miss_limit, logic has_recovery);
        wd_req_t req;
        req.mode         = mode;
        req.slot         = slot;
        req.now_ms       = now_ms;
        req.interval_ms  = interval_ms;
        req.miss_limit   = miss_limit;
        req.has_recovery = has_recovery;
        return req;
    endfunction

    // Applies one transaction to the slot table and returns the result it must give.
    function automatic mstw_pkg::result_t watchdog_predict(wd_req_t req);
        mstw_pkg::result_t res;
        bit                claimed;
        int                fired;
        logic [63:0]       elapsed;
        logic [7:0]        misses;
        res     = '0;
        claimed = 1'b0;
        fired   = 0;
        case (req.mode)
            mstw_pkg::MODE_REGISTER:
            begin
                // Lowest free slot that a handle can name; a full table changes nothing.
                for (int i = 0; i < mstw_pkg::HANDLE_SLOTS; i++)
                begin
                    if (!claimed && !wd_used[i])
                    begin
                        claimed          = 1'b1;
                        wd_used[i]       = 1'b1;
                        wd_timeout[i]    = req.interval_ms;
                        wd_limit[i]      = req.miss_limit;
                        wd_misses[i]     = '0;
                        wd_last_kick[i]  = req.now_ms;
                        wd_recovery[i]   = req.has_recovery;
                        res.handle       = i[2:0];
                        res.handle_valid = 1'b1;
                    end
                end
            end
            mstw_pkg::MODE_KICK:
            begin
                // A kick on a slot that was never registered is dropped silently.
                if (req.slot < mstw_pkg::SLOTS && wd_used[req.slot])
                begin
                    wd_last_kick[req.slot] = req.now_ms;
                    wd_misses[req.slot]    = '0;
                end
            end
            mstw_pkg::MODE_CHECK:
            begin
                for (int i = 0; i < mstw_pkg::SLOTS; i++)
                begin
                    elapsed = req.now_ms - wd_last_kick[i];
                    if (wd_used[i] && elapsed > {32'd0, wd_timeout[i]})
                    begin
                        misses = wd_misses[i] + 8'd1;
                        wd_misses[i] = misses;
                        // A limit of zero fires on the first miss.
                        if (misses >= wd_limit[i])
                        begin
                            wd_misses[i]    = '0;
                            wd_last_kick[i] = req.now_ms;
                            if (fired < 15)
                                fired++;
                            if (wd_recovery[i] && i < mstw_pkg::MASK_W)
                                res.recovery_mask[i] = 1'b1;
                        end
                    end
                end
                res.fired_count = fired[mstw_pkg::FIRED_W-1:0];
            end
            default:
            begin
                // Reserved kind: no state change, all result fields zero.
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Driver: offers the queued requests, idling at random except in the quiet window.
    // The prediction is taken when a transaction is accepted, so stalls never skew it.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        wd_req_t nxt;
        bit      quiet;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(watchdog_predict(offered_req));
                reqs_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                quiet = (reqs_accepted >= QUIET_LO) && (reqs_accepted < QUIET_HI);
                if (pending_reqs.size() > 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, nxt.has_recovery, nxt.miss_limit,
                                      nxt.interval_ms, nxt.now_ms, nxt.slot};
                    s_axis_tuser  <= nxt.mode;
                    offered_req   <= nxt;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transaction with the oldest prediction and
    // drives the receiver's ready, including one long hold-off that backs up the core.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        mstw_pkg::result_t got;
        mstw_pkg::result_t want;
        logic              ready_nxt;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    $error("result 0x%h arrived with no prediction waiting", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("handle", 32'(want.handle), 32'(got.handle));
                    check_field("handle_valid", 32'(want.handle_valid),
                                32'(got.handle_valid));
                    check_field("fired_count", 32'(want.fired_count),
                                32'(got.fired_count));
                    check_field("recovery_mask", 32'(want.recovery_mask),
                                32'(got.recovery_mask));
                end
                results_seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_nxt = 1'b0;
            end
            else if (!stall_done && results_seen >= STALL_AT)
            begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                ready_nxt  = 1'b0;
            end
            else
            begin
                ready_nxt = (results_seen >= QUIET_LO && results_seen < QUIET_HI)
                            || $urandom_range(0, 99) >= IDLE_PCT;
            end
            m_axis_tready <= ready_nxt;
        end
    end

    // Ends the run if neither side completes a transaction for too long.
    initial
    begin : hang_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] clock_ms;
        logic [31:0] tmo;
        logic [7:0]  lim;
        logic [1:0]  mode;
        logic [2:0]  slot;
        logic [63:0] stamp;
        int          roll;

        for (int i = 0; i < mstw_pkg::SLOTS; i++)
        begin
            wd_used[i]      = 1'b0;
            wd_timeout[i]   = '0;
            wd_limit[i]     = '0;
            wd_misses[i]    = '0;
            wd_last_kick[i] = '0;
            wd_recovery[i]  = 1'b0;
        end

        // Directed part. An empty table, a kick on an unused slot and a reserved
        // kind all return zeros.
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, 64'd0, 32'd0, 8'd0,
                                        1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_KICK, 3'd0, 64'd5, 32'd0, 8'd0,
                                        1'b0));
        pending_reqs.push_back(make_req(MODE_RESERVED, 3'd7, '1, '1, '1, 1'b1));
        // Slot 0 fires at its first miss; slot 1 has the widest timeout and limit.
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0, 32'd0, 8'd0,
                                        1'b1));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0, '1, 8'd255,
                                        1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0, 32'd10, 8'd2,
                                        1'b1));
        // Zero elapsed time, then checks whose elapsed time wraps past zero.
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0, 32'd0, 8'd0,
                                        1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0 + 64'd1, 32'd0,
                                        8'd0, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0 + 64'd20, 32'd0,
                                        8'd0, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0 + 64'd21, 32'd0,
                                        8'd0, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_KICK, 3'd2, T0 + 64'd25, 32'd0,
                                        8'd0, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_KICK, 3'd7, T0 + 64'd26, 32'd0,
                                        8'd0, 1'b0));
        // Fill the table. Slot 7 is never kicked in the random part, so it
        // eventually walks its miss count all the way up to 255.
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0 + 64'd30, 32'd5,
                                        8'd1, 1'b1));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0 + 64'd30, 32'd20,
                                        8'd3, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0 + 64'd30,
                                        32'd100, 8'd2, 1'b1));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0 + 64'd30, 32'd1,
                                        8'd1, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd0, T0 + 64'd30, 32'd0,
                                        8'd255, 1'b1));
        // Table full.
        pending_reqs.push_back(make_req(mstw_pkg::MODE_REGISTER, 3'd5, T0 + 64'd40, 32'd7,
                                        8'd1, 1'b1));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0 + 64'd60, 32'd0,
                                        8'd0, 1'b0));
        // A time earlier than the last kick looks like an enormous elapsed time.
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0 + 64'd29, 32'd0,
                                        8'd0, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_KICK, 3'd4, T0 + 64'd70, 32'd0,
                                        8'd0, 1'b0));
        pending_reqs.push_back(make_req(mstw_pkg::MODE_CHECK, 3'd0, T0 + 64'd200, 32'd0,
                                        8'd0, 1'b0));

        // Random part: a steadily advancing clock with kicks and checks, plus
        // occasional jumps, further registrations into a full table, reserved
        // kinds and kicks stamped with unrelated times.
        clock_ms = T0 + 64'd200;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            roll = int'($urandom_range(0, 99));
            if ($urandom_range(0, 49) == 0)
                clock_ms = {$urandom, $urandom};
            else
                clock_ms = clock_ms + 64'($urandom_range(0, 30));
            case ($urandom_range(0, 3))
                0:       tmo = 32'd0;
                1:       tmo = $urandom_range(0, 40);
                2:       tmo = '1;
                default: tmo = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       lim = 8'($urandom_range(0, 3));
                1:       lim = 8'd255;
                default: lim = 8'($urandom);
            endcase
            slot  = 3'($urandom_range(0, 7));
            stamp = clock_ms;
            if (roll < 5)
            begin
                mode = mstw_pkg::MODE_REGISTER;
            end
            else if (roll < 45)
            begin
                mode = mstw_pkg::MODE_KICK;
                slot = 3'($urandom_range(0, 6));
            end
            else if (roll < 92)
            begin
                mode = mstw_pkg::MODE_CHECK;
            end
            else if (roll < 96)
            begin
                mode = MODE_RESERVED;
            end
            else
            begin
                mode  = mstw_pkg::MODE_KICK;
                slot  = 3'($urandom_range(0, 6));
                stamp = {$urandom, $urandom};
            end
            pending_reqs.push_back(make_req(mode, slot, stamp, tmo, lim,
                                            1'($urandom_range(0, 1))));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: multi_slot_task_watchdog_core.f
rtl/core/mstw_pkg.sv
rtl/core/mstw_front.sv
rtl/core/mstw_queue.sv
rtl/core/mstw_engine.sv
rtl/core/multi_slot_task_watchdog_core.sv
dv/multi_slot_task_watchdog_core_tb.sv
